FILE: src/spf_pkg.sv
// shared types and constants for the stateful packet filter
package spf_pkg;

  localparam logic [1:0] CMD_CHECK  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_EXPIRE = 2'd3;

  localparam logic [63:0] TIMEOUT_RESET = 64'd60000;
  localparam logic [5:0]  MAX_PREFIX    = 6'd32;
  localparam logic [5:0]  EXP_SAT       = 6'd63;

  typedef struct packed {
    logic [1:0]  command;
    logic        direction;
    logic [1:0]  protocol;
    logic [31:0] own_addr;
    logic [15:0] own_port;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [63:0] timestamp_ms;
    logic        rule_action;
    logic [5:0]  rule_prefix_len;
    logic [7:0]  slot_index;
  } spf_in_t;

  typedef struct packed {
    logic        status;
    logic        allowed;
    logic        via_flow;
    logic [5:0]  expired_count;
    logic [31:0] denied_total;
  } spf_out_t;

  // rule entry: kind bits (action, direction, protocol), ports, prefix, length
  typedef struct packed {
    logic        action;
    logic        direction;
    logic [1:0]  protocol;
    logic [15:0] lport;
    logic [15:0] rport;
    logic [31:0] prefix;
    logic [5:0]  plen;
  } spf_rule_t;

  typedef struct packed {
    logic [1:0]  protocol;
    logic [31:0] lip;
    logic [31:0] rip;
    logic [15:0] lport;
    logic [15:0] rport;
  } spf_flow_t;

  function automatic logic [31:0] mask_of(input logic [5:0] len);
    logic [31:0] m;
    m = '0;
    if (len == 6'd0) m = '0;
    else if (len > MAX_PREFIX) m = '1;
    else m = 32'hFFFF_FFFF << (6'd32 - len);
    return m;
  endfunction

endpackage

FILE: src/spf_ram.sv
// generic ram with one write port and one registered read port
module spf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: src/stateful_packet_filter_core.sv
// stateful packet filter top level: sequencer, tables and apb register
// Usage: one command per input transfer on in_valid_i/in_stall_o, one result
// transfer per command on out_valid_o/out_stall_i. The block handles one
// command at a time; in_stall_o is high from acceptance until the sequencer
// is idle again.
// An ingress check scans the flow table one slot per cycle, then, on a miss,
// the rule table one slot per cycle. An egress check scans only the rules,
// then opens a flow when allowed and a flow slot is free. An expire scans
// the flow table; an add or a remove goes straight to the result. Each
// table has one registered read port. No new command is taken before the
// result of the current one has been raised.
// Reset clears the valid bits, the denied counter and the sequencer, and
// loads idle_timeout_ms with 60000; table contents are not cleared.
// A stalled result stays in the output register; the next command still
// runs and waits in its last state until that result has been transferred.
// idle_timeout_ms is written over apb at byte address 0 (64-bit data).
module stateful_packet_filter_core import spf_pkg::*; #(
  parameter int RULE_SLOTS = 16,
  parameter int FLOW_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  spf_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output spf_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam int RW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int FW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CW = 9;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FLOW   = 3'd1;
  localparam logic [2:0] S_RULE   = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_EXPIRE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]    state_q, state_d;
  spf_in_t       cmd_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [RULE_SLOTS-1:0] rule_valid_q, rule_valid_d;
  logic [FLOW_SLOTS-1:0] flow_valid_q, flow_valid_d;
  logic [31:0]   denied_q, denied_d;
  logic [63:0]   timeout_q;
  spf_out_t      res_q, res_d;
  spf_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;

  // ram ports
  logic          rule_we, flow_we, seen_we;
  logic [RW-1:0] rule_waddr, rule_raddr;
  logic [FW-1:0] flow_waddr, flow_raddr, seen_waddr, seen_raddr;
  spf_rule_t     rule_wdata, rule_rdata;
  spf_flow_t     flow_wdata, flow_rdata;
  logic [63:0]   seen_wdata, seen_rdata;

  spf_ram #(.Width($bits(spf_rule_t)), .Depth(RULE_SLOTS)) u_rule_ram (
    .clk_i, .we_i(rule_we), .waddr_i(rule_waddr), .wdata_i(rule_wdata),
    .raddr_i(rule_raddr), .rdata_o(rule_rdata));
  spf_ram #(.Width($bits(spf_flow_t)), .Depth(FLOW_SLOTS)) u_flow_ram (
    .clk_i, .we_i(flow_we), .waddr_i(flow_waddr), .wdata_i(flow_wdata),
    .raddr_i(flow_raddr), .rdata_o(flow_rdata));
  spf_ram #(.Width(64), .Depth(FLOW_SLOTS)) u_seen_ram (
    .clk_i, .we_i(seen_we), .waddr_i(seen_waddr), .wdata_i(seen_wdata),
    .raddr_i(seen_raddr), .rdata_o(seen_rdata));

  // entry read this cycle belongs to index idx_q-1 (registered read)
  logic [CW-1:0] rd_idx;
  logic          rd_ok;
  assign rd_idx = idx_q - CW'(1);
  assign rd_ok  = (idx_q != '0);

  logic accept, cfg_wr;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? timeout_q : 64'd0;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // 64-bit subtract, used for expiry age
  logic [64:0] diff;
  assign diff = {1'b0, cmd_q.timestamp_ms} - {1'b0, seen_rdata};

  logic flow_hit, rule_hit;
  logic [31:0] rmask;
  always_comb begin
    flow_hit = flow_rdata.protocol == cmd_q.protocol &&
      ((flow_rdata.lip == cmd_q.own_addr && flow_rdata.rip == cmd_q.peer_addr &&
        flow_rdata.lport == cmd_q.own_port && flow_rdata.rport == cmd_q.peer_port) ||
       (flow_rdata.lip == cmd_q.peer_addr && flow_rdata.rip == cmd_q.own_addr &&
        flow_rdata.lport == cmd_q.peer_port && flow_rdata.rport == cmd_q.own_port));
    rmask = mask_of(rule_rdata.plen);
    rule_hit = rule_rdata.direction == cmd_q.direction &&
      (rule_rdata.protocol == 2'd0 || rule_rdata.protocol == cmd_q.protocol) &&
      (rule_rdata.lport == 16'd0 || rule_rdata.lport == cmd_q.own_port) &&
      (rule_rdata.rport == 16'd0 || rule_rdata.rport == cmd_q.peer_port) &&
      ((cmd_q.peer_addr & rmask) == (rule_rdata.prefix & rmask));
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    rule_valid_d = rule_valid_q;
    flow_valid_d = flow_valid_q;
    denied_d = denied_q;
    res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rule_we = 1'b0;
    flow_we = 1'b0;
    seen_we = 1'b0;
    rule_waddr = rd_idx[RW-1:0];
    flow_waddr = rd_idx[FW-1:0];
    seen_waddr = rd_idx[FW-1:0];
    rule_raddr = idx_q[RW-1:0];
    flow_raddr = idx_q[FW-1:0];
    seen_raddr = idx_q[FW-1:0];
    rule_wdata.action    = cmd_q.rule_action;
    rule_wdata.direction = cmd_q.direction;
    rule_wdata.protocol  = cmd_q.protocol;
    rule_wdata.lport     = cmd_q.own_port;
    rule_wdata.rport     = cmd_q.peer_port;
    rule_wdata.prefix    = cmd_q.peer_addr & mask_of(cmd_q.rule_prefix_len);
    rule_wdata.plen      = cmd_q.rule_prefix_len;
    flow_wdata.protocol  = cmd_q.protocol;
    flow_wdata.lip       = cmd_q.own_addr;
    flow_wdata.rip       = cmd_q.peer_addr;
    flow_wdata.lport     = cmd_q.own_port;
    flow_wdata.rport     = cmd_q.peer_port;
    seen_wdata = cmd_q.timestamp_ms;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d = '0;
          res_d = '0;
          case (in_data_i.command)
            CMD_CHECK:  state_d = in_data_i.direction ? S_RULE : S_FLOW;
            CMD_ADD: begin
              if (in_data_i.rule_prefix_len > MAX_PREFIX) begin
                res_d.status = 1'b1;
                state_d = S_DONE;
              end else if (&rule_valid_q) begin
                res_d.status = 1'b1;
                state_d = S_DONE;
              end else begin
                // add writes the lowest free slot directly
                state_d = S_DONE;
                for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
                  if (!rule_valid_q[i]) rule_waddr = RW'(i);
                end
                rule_we = 1'b1;
                rule_valid_d[rule_waddr] = 1'b1;
                rule_wdata.action    = in_data_i.rule_action;
                rule_wdata.direction = in_data_i.direction;
                rule_wdata.protocol  = in_data_i.protocol;
                rule_wdata.lport     = in_data_i.own_port;
                rule_wdata.rport     = in_data_i.peer_port;
                rule_wdata.prefix    = in_data_i.peer_addr &
                                       mask_of(in_data_i.rule_prefix_len);
                rule_wdata.plen      = in_data_i.rule_prefix_len;
              end
            end
            CMD_REMOVE: begin
              state_d = S_DONE;
              if (32'(in_data_i.slot_index) < RULE_SLOTS &&
                  rule_valid_q[in_data_i.slot_index[RW-1:0]])
                rule_valid_d[in_data_i.slot_index[RW-1:0]] = 1'b0;
              else
                res_d.status = 1'b1;
            end
            default: state_d = S_EXPIRE;
          endcase
        end
      end
      S_FLOW: begin
        idx_d = idx_q + CW'(1);
        if (rd_ok && flow_valid_q[rd_idx[FW-1:0]] && flow_hit) begin
          seen_we = 1'b1;
          res_d.allowed = 1'b1;
          res_d.via_flow = 1'b1;
          state_d = S_DONE;
        end else if (32'(idx_q) == FLOW_SLOTS) begin
          idx_d = '0;
          state_d = S_RULE;
        end
      end
      S_RULE: begin
        idx_d = idx_q + CW'(1);
        if (rd_ok && rule_valid_q[rd_idx[RW-1:0]] && rule_hit) begin
          if (rule_rdata.action) begin
            res_d.allowed = 1'b1;
            if (cmd_q.direction) begin
              idx_d = '0;
              state_d = S_INSERT;
            end else state_d = S_DONE;
          end else begin
            denied_d = denied_q + 32'd1;
            state_d = S_DONE;
          end
        end else if (32'(idx_q) == RULE_SLOTS) begin
          denied_d = denied_q + 32'd1;
          state_d = S_DONE;
        end
      end
      S_INSERT: begin
        state_d = S_DONE;
        if (!(&flow_valid_q)) begin
          for (int i = FLOW_SLOTS - 1; i >= 0; i--) begin
            if (!flow_valid_q[i]) flow_waddr = FW'(i);
          end
          seen_waddr = flow_waddr;
          flow_we = 1'b1;
          seen_we = 1'b1;
          flow_valid_d[flow_waddr] = 1'b1;
        end
      end
      S_EXPIRE: begin
        idx_d = idx_q + CW'(1);
        if (rd_ok && flow_valid_q[rd_idx[FW-1:0]] && !diff[64] &&
            diff[63:0] >= timeout_q) begin
          flow_valid_d[rd_idx[FW-1:0]] = 1'b0;
          if (res_d.expired_count != EXP_SAT)
            res_d.expired_count = res_q.expired_count + 6'd1;
        end
        if (32'(idx_q) == FLOW_SLOTS) state_d = S_DONE;
      end
      S_DONE: begin
        // hold here while the previous result is still stalled
        if (!out_valid_q || !out_stall_i) begin
          out_d = res_q;
          out_d.denied_total = denied_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      rule_valid_q <= '0;
      flow_valid_q <= '0;
      denied_q <= '0;
      timeout_q <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      rule_valid_q <= rule_valid_d;
      flow_valid_q <= flow_valid_d;
      denied_q <= denied_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr && paddr == 1'b0) timeout_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
    if (accept) cmd_q <= in_data_i;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !accept) else $error("transfer taken while busy");
  a_done_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_q) else $error("result not raised");
  a_denied_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (denied_q != $past(denied_q)) |-> (denied_q == $past(denied_q) + 32'd1))
    else $error("denied counter jumped");
  a_via_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.via_flow || out_q.allowed))
    else $error("flow hit without allow");
`endif
endmodule

FILE: test/tb_stateful_packet_filter_core.sv
// testbench for the stateful packet filter core: commands checked against a predictor
`timescale 1ns / 1ps

module tb_stateful_packet_filter_core;
  import spf_pkg::*;

  localparam int NRULE = 16;
  localparam int NFLOW = 32;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  spf_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  spf_out_t    out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  stateful_packet_filter_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state
  logic        rv[NRULE];
  spf_rule_t   rtab[NRULE];
  logic        fv[NFLOW];
  spf_flow_t   ftab[NFLOW];
  logic [63:0] fseen[NFLOW];
  logic [31:0] denied_cnt;
  logic [63:0] idle_timeout;

  spf_in_t  cmd_queue[$];
  spf_out_t verdict_queue[$];
  int       mismatches;
  int       results_seen;
  longint   cycles;
  int       idle_pct;
  int       hold_cycles;

  function automatic logic [31:0] mask_for_len(input logic [5:0] len);
    if (len == 0) return 32'h0;
    if (len > 32) return 32'hFFFF_FFFF;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic spf_out_t predict_filter(input spf_in_t c);
    spf_out_t r;
    bit       hit;
    logic     verdict;
    int       i;
    r = '0;
    hit = 0;
    verdict = 0;
    case (c.command)
      CMD_CHECK: begin
        if (c.direction == 1'b0) begin
          for (i = 0; i < NFLOW && !hit; i++) begin
            if (fv[i] && ftab[i].protocol == c.protocol &&
                ((ftab[i].lip == c.own_addr && ftab[i].rip == c.peer_addr &&
                  ftab[i].lport == c.own_port && ftab[i].rport == c.peer_port) ||
                 (ftab[i].lip == c.peer_addr && ftab[i].rip == c.own_addr &&
                  ftab[i].lport == c.peer_port && ftab[i].rport == c.own_port))) begin
              fseen[i] = c.timestamp_ms;
              hit = 1;
            end
          end
        end
        if (hit) begin
          r.allowed = 1;
          r.via_flow = 1;
        end else begin
          for (i = 0; i < NRULE; i++) begin
            if (rv[i] && rtab[i].direction == c.direction &&
                (rtab[i].protocol == 0 || rtab[i].protocol == c.protocol) &&
                (rtab[i].lport == 0 || rtab[i].lport == c.own_port) &&
                (rtab[i].rport == 0 || rtab[i].rport == c.peer_port) &&
                (c.peer_addr & mask_for_len(rtab[i].plen)) ==
                (rtab[i].prefix & mask_for_len(rtab[i].plen))) begin
              verdict = rtab[i].action;
              break;
            end
          end
          if (!verdict) denied_cnt++;
          else if (c.direction) begin
            for (i = 0; i < NFLOW; i++) begin
              if (!fv[i]) begin
                fv[i] = 1;
                ftab[i].protocol = c.protocol;
                ftab[i].lip = c.own_addr;
                ftab[i].rip = c.peer_addr;
                ftab[i].lport = c.own_port;
                ftab[i].rport = c.peer_port;
                fseen[i] = c.timestamp_ms;
                break;
              end
            end
          end
          r.allowed = verdict;
        end
      end
      CMD_ADD: begin
        r.status = 1;
        if (c.rule_prefix_len <= 32) begin
          for (i = 0; i < NRULE; i++) begin
            if (!rv[i]) begin
              rv[i] = 1;
              rtab[i].action = c.rule_action;
              rtab[i].direction = c.direction;
              rtab[i].protocol = c.protocol;
              rtab[i].lport = c.own_port;
              rtab[i].rport = c.peer_port;
              rtab[i].prefix = c.peer_addr & mask_for_len(c.rule_prefix_len);
              rtab[i].plen = c.rule_prefix_len;
              r.status = 0;
              break;
            end
          end
        end
      end
      CMD_REMOVE: begin
        if (c.slot_index < NRULE && rv[c.slot_index]) rv[c.slot_index] = 0;
        else r.status = 1;
      end
      default: begin
        for (i = 0; i < NFLOW; i++) begin
          if (fv[i] && c.timestamp_ms >= fseen[i] &&
              c.timestamp_ms - fseen[i] >= idle_timeout) begin
            fv[i] = 0;
            if (r.expired_count < 63) r.expired_count++;
          end
        end
      end
    endcase
    r.denied_total = denied_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // driver: predicts at the accepting edge, then offers the next transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        verdict_queue.push_back(predict_filter(in_data_i));
        void'(cmd_queue.pop_front());
      end
      if ((in_valid_i && in_stall_o) ||
          (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct)) begin
        in_valid_i <= 1;
        in_data_i <= (in_valid_i && in_stall_o) ? in_data_i : cmd_queue[0];
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    spf_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd0);
        end else begin
          want = verdict_queue.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
          if (out_data_o.allowed !== want.allowed)
            report_mismatch("allowed", 64'(out_data_o.allowed), 64'(want.allowed));
          if (out_data_o.via_flow !== want.via_flow)
            report_mismatch("via_flow", 64'(out_data_o.via_flow), 64'(want.via_flow));
          if (out_data_o.expired_count !== want.expired_count)
            report_mismatch("expired_count", 64'(out_data_o.expired_count),
                            64'(want.expired_count));
          if (out_data_o.denied_total !== want.denied_total)
            report_mismatch("denied_total", 64'(out_data_o.denied_total),
                            64'(want.denied_total));
        end
        results_seen++;
      end
    end
  end

  // receiver stall, with long hold-offs counted here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  task automatic apb_write(input logic [63:0] value);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= value; penable <= 0;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    idle_timeout = value;
  endtask

  task automatic drain_results();
    while (cmd_queue.size() != 0 || in_valid_i || verdict_queue.size() != 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic spf_in_t random_packet(input logic [1:0] cmd);
    spf_in_t c;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(spf_in_t)-1:0];
    c.command = cmd;
    // small address and port pools so flows and rules actually match
    if ($urandom_range(3) != 0) begin
      c.own_addr = 32'h0A00_0000 | $urandom_range(3);
      c.peer_addr = 32'hC0A8_0000 | ($urandom_range(3) << 8) | $urandom_range(3);
      c.own_port = $urandom_range(1) ? 16'd80 : 16'd443;
      c.peer_port = 16'(16'd1000 + $urandom_range(2));
    end
    if ($urandom_range(3) != 0) c.rule_prefix_len = 6'($urandom_range(32));
    if ($urandom_range(3) != 0) c.slot_index = 8'($urandom_range(NRULE));
    if (cmd == CMD_ADD && $urandom_range(2) != 0) begin
      if ($urandom_range(1)) c.own_port = 0;
      if ($urandom_range(1)) c.peer_port = 0;
    end
    return c;
  endfunction

  task automatic push_random(input int n);
    spf_in_t c;
    logic [63:0] now;
    now = 64'd1000;
    repeat (n) begin
      now = now + $urandom_range(20000);
      case ($urandom_range(9))
        0, 1: c = random_packet(CMD_ADD);
        2: c = random_packet(CMD_REMOVE);
        3: c = random_packet(CMD_EXPIRE);
        default: c = random_packet(CMD_CHECK);
      endcase
      if (c.command != CMD_ADD && c.command != CMD_REMOVE && $urandom_range(7) != 0)
        c.timestamp_ms = now;
      // replay a reversed tracked flow now and then
      if (c.command == CMD_CHECK && $urandom_range(2) == 0) begin
        c.direction = 0;
        {c.own_addr, c.peer_addr} = {c.peer_addr, c.own_addr};
        {c.own_port, c.peer_port} = {c.peer_port, c.own_port};
      end
      cmd_queue.push_back(c);
    end
  endtask

  initial begin
    spf_in_t c;
    int i;
    rst_ni = 0; in_valid_i = 0; in_data_i = '0; out_stall_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    cycles = 0; mismatches = 0; results_seen = 0; hold_cycles = 0;
    idle_pct = 24; denied_cnt = 0; idle_timeout = TIMEOUT_RESET;
    for (i = 0; i < NRULE; i++) begin rv[i] = 0; rtab[i] = '0; end
    for (i = 0; i < NFLOW; i++) begin fv[i] = 0; ftab[i] = '0; fseen[i] = 0; end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;

    // directed: rules, bad prefix, bad slots, flow hits, table overflows
    c = '0; c.command = CMD_CHECK; cmd_queue.push_back(c);
    c.command = CMD_REMOVE; c.slot_index = 8'hFF; cmd_queue.push_back(c);
    c.slot_index = 0; cmd_queue.push_back(c);
    c.command = CMD_ADD; c.rule_prefix_len = 6'd63; cmd_queue.push_back(c);
    c.rule_prefix_len = 6'd33; cmd_queue.push_back(c);
    c.rule_prefix_len = 6'd32; c.direction = 1; c.rule_action = 1;
    c.peer_addr = '1; cmd_queue.push_back(c);
    c.rule_prefix_len = 0; c.peer_addr = 32'h1234_5678; cmd_queue.push_back(c);
    c.direction = 0; c.rule_action = 0; c.protocol = 3; c.own_port = '1;
    c.peer_port = '1; c.rule_prefix_len = 8; cmd_queue.push_back(c);
    c = '1; c.command = CMD_CHECK; c.timestamp_ms = '1; cmd_queue.push_back(c);
    c.direction = 0; cmd_queue.push_back(c);
    for (i = 0; i < 34; i++) begin
      c = '0; c.command = CMD_CHECK; c.direction = 1; c.protocol = 2'(i % 4);
      c.own_addr = i; c.peer_port = 16'(i); c.timestamp_ms = 64'd100 * i;
      cmd_queue.push_back(c);
    end
    c = '0; c.command = CMD_CHECK; c.protocol = 1; c.peer_addr = 1; c.own_port = 1;
    c.peer_port = 0; c.timestamp_ms = 64'd5; cmd_queue.push_back(c);
    c = '0; c.command = CMD_EXPIRE; c.timestamp_ms = 64'd2000; cmd_queue.push_back(c);
    c.timestamp_ms = '1; cmd_queue.push_back(c);
    for (i = 0; i < 17; i++) begin
      c = random_packet(CMD_ADD); c.rule_prefix_len = 6'(i); cmd_queue.push_back(c);
    end
    drain_results();

    // expire everything at once with a zero timeout
    apb_write(64'd0);
    for (i = 0; i < 34; i++) begin
      c = '0; c.command = CMD_CHECK; c.direction = 1; c.own_addr = i;
      c.timestamp_ms = 64'd50; cmd_queue.push_back(c);
    end
    c = '0; c.command = CMD_EXPIRE; c.timestamp_ms = 64'd10; cmd_queue.push_back(c);
    c.timestamp_ms = 64'd50; cmd_queue.push_back(c);
    for (i = 0; i < NRULE; i++) begin
      c = '0; c.command = CMD_REMOVE; c.slot_index = 8'(i); cmd_queue.push_back(c);
    end
    drain_results();

    // receiver holds off while the sender keeps offering
    apb_write(64'd30000);
    push_random(40);
    hold_cycles = 400;
    drain_results();

    apb_write(64'hFFFF_FFFF_FFFF_FFFF);
    push_random(250);
    drain_results();

    apb_write(64'd15000);
    idle_pct = 0;
    push_random(250);
    drain_results();

    idle_pct = 24;
    push_random(400);
    drain_results();

    $display("ran %0d commands over %0d cycles with five timeout settings", results_seen, cycles);
    $display("including full rule and flow tables, mass expiry and long output stalls");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
src/spf_pkg.sv
src/spf_ram.sv
src/stateful_packet_filter_core.sv
test/tb_stateful_packet_filter_core.sv
